### hdl/mwdl_pkg.sv
package mwdl_pkg;

  localparam int DATA_W = 40;
  localparam int ACC_W  = 64;
  localparam int QDEPTH = 4;

  localparam logic [1:0] REG_BATCH_COUNT   = 2'd0;
  localparam logic [1:0] REG_WEIGHTED_MODE = 2'd1;
  localparam logic [1:0] REG_GRAD_SCALE    = 2'd2;
  localparam logic [1:0] REG_MASK_CODE     = 2'd3;

  typedef struct packed {
    logic [10:0]        batch_count;
    logic               weighted_mode;
    logic [DATA_W-1:0]  grad_scale;
    logic [DATA_W-1:0]  mask_code;
  } cfg_t;

  // classified pixel as it leaves the front end
  typedef struct packed {
    logic [DATA_W:0]    diff;     // predicted - target, 0 when masked
    logic [DATA_W-1:0]  u;        // weight magnitude, or one when masked or unweighted
    logic               wneg;     // weight sign
    logic               gterm;    // weighted and not masked
    logic               last;
  } item_t;

  typedef struct packed {
    logic [ACC_W-1:0] loss;
    logic [ACC_W-1:0] gw;
    logic [ACC_W-1:0] gt;
    logic [ACC_W-1:0] gp;
    logic             math_error;
    logic             eob;
  } res_t;

endpackage

### hdl/mwdl_front.sv
module mwdl_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mwdl_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [mwdl_pkg::DATA_W-1:0] pred,
  input  logic [mwdl_pkg::DATA_W-1:0] targ,
  input  logic [mwdl_pkg::DATA_W-1:0] wt,
  input  logic                    last,
  output logic                    q_valid,
  input  logic                    q_ready,
  output mwdl_pkg::item_t         q_item
);
  import mwdl_pkg::*;

  localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic  masked;

  always_comb begin
    masked = (targ == cfg.mask_code);
    item_nxt.diff  = masked ? '0 : ({pred[DATA_W-1], pred} - {targ[DATA_W-1], targ});
    if (masked || !cfg.weighted_mode) begin
      item_nxt.u = ONE;
    end else begin
      item_nxt.u = wt[DATA_W-1] ? (DATA_W'(0) - wt) : wt;
    end
    item_nxt.wneg  = wt[DATA_W-1];
    item_nxt.gterm = cfg.weighted_mode && !masked;
    item_nxt.last  = last;
  end

  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

### hdl/mwdl_fifo.sv
module mwdl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  mwdl_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output mwdl_pkg::item_t rd_item
);
  import mwdl_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  item_t         mem_r [QDEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

### hdl/mwdl_mul.sv
module mwdl_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);
  import mwdl_pkg::*;

  logic         busy_r;
  logic [2:0]   cnt_r;
  logic [63:0]  x_r;
  logic [63:0]  y_r;
  logic         neg_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic         done_r;
  logic [63:0]  res_r;

  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [127:0] term;
  logic [127:0] sh;
  logic [63:0]  slo;
  logic [63:0]  res_nxt;

  // partial products xl*yl, xl*yh, xh*yl, xh*yh, one a cycle
  always_comb begin
    xs = (cnt_r[1]) ? x_r[63:32] : x_r[31:0];
    ys = (cnt_r[0]) ? y_r[63:32] : y_r[31:0];
    case (cnt_r)
      3'd1:    term = {64'd0, pp_r};
      3'd2:    term = {32'd0, pp_r, 32'd0};
      3'd3:    term = {32'd0, pp_r, 32'd0};
      3'd4:    term = {pp_r, 64'd0};
      default: term = '0;
    endcase
    sh  = acc_r >> FRAC_BITS;
    slo = (|sh[127:64]) ? '1 : sh[63:0];
    if (neg_r) begin
      res_nxt = (slo > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : (64'd0 - slo);
    end else begin
      res_nxt = (slo > 64'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : slo;
    end
  end

  assign done = done_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (done_r) done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      x_r   <= a[63] ? (64'd0 - a) : a;
      y_r   <= b[63] ? (64'd0 - b) : b;
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) pp_r <= 64'(xs * ys);
      acc_r <= acc_r + term;
      if (cnt_r == 3'd5) res_r <= res_nxt;
    end
  end

endmodule

### hdl/mwdl_div.sv
module mwdl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);
  import mwdl_pkg::*;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] n_r;
  logic [63:0] d_r;
  logic [64:0] r_r;
  logic [63:0] q_r;
  logic        done_r;
  logic [64:0] r_t;
  logic        ge;

  // restoring division, one quotient bit a cycle
  assign r_t  = {r_r[63:0], n_r[63]};
  assign ge   = (r_t >= {1'b0, d_r});
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (done_r) done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      n_r <= num;
      d_r <= den;
      r_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[62:0], 1'b0};
      r_r <= ge ? (r_t - {1'b0, d_r}) : r_t;
      q_r <= {q_r[62:0], ge};
    end
  end

endmodule

### hdl/mwdl_back.sv
module mwdl_back #(
  parameter int FRAC_BITS      = 16,
  parameter int LOG_TABLE_SIZE = 256,
  parameter int MAX_BATCH      = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mwdl_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_ready,
  input  mwdl_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output mwdl_pkg::res_t  out_res
);
  import mwdl_pkg::*;

  localparam int BW = $clog2(MAX_BATCH + 1);
  localparam int CW = (BW > 11) ? BW : 11;
  localparam int KW = $clog2(LOG_TABLE_SIZE);
  localparam logic [63:0] SMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] RND  = 64'd1 << (29 - FRAC_BITS);

  typedef logic [63:0] ltab_t [LOG_TABLE_SIZE];

  function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2*atanh(num/den) series, i.e. ln((den+num)/(den-num)), Q30
  function automatic logic [63:0] ln_series(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    z    = cdiv(num << 30, den);
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    for (int n = 1; n < 200; n += 2) begin
      if (term != 0) begin
        sum  = sum + cdiv(term, 64'(n));
        term = (term * z2) >> 30;
      end
    end
    return sum << 1;
  endfunction

  function automatic ltab_t build_tab();
    ltab_t t;
    for (int k = 0; k < LOG_TABLE_SIZE; k++) begin
      t[k] = ln_series(64'(k), 64'(2 * LOG_TABLE_SIZE + k));
    end
    return t;
  endfunction

  localparam ltab_t LOG_TAB = build_tab();
  localparam logic [63:0] LN2_Q30 = ln_series(64'd1, 64'd3);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_neg(input logic [63:0] a);
    return (a == SMIN) ? SMAX : (64'd0 - a);
  endfunction

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ALPHA = 5'd1;
  localparam logic [4:0] ST_M1    = 5'd2;
  localparam logic [4:0] ST_M2    = 5'd3;
  localparam logic [4:0] ST_M3    = 5'd4;
  localparam logic [4:0] ST_M4    = 5'd5;
  localparam logic [4:0] ST_M5    = 5'd6;
  localparam logic [4:0] ST_M6    = 5'd7;
  localparam logic [4:0] ST_DIVQ  = 5'd8;
  localparam logic [4:0] ST_LNORM = 5'd9;
  localparam logic [4:0] ST_LK    = 5'd10;
  localparam logic [4:0] ST_LT    = 5'd11;
  localparam logic [4:0] ST_LSUM  = 5'd12;
  localparam logic [4:0] ST_COMB  = 5'd13;
  localparam logic [4:0] ST_FIN   = 5'd14;
  localparam logic [4:0] ST_LD1   = 5'd15;
  localparam logic [4:0] ST_LD2   = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0]  st_r;
  item_t       it_r;
  logic [63:0] alpha_r;
  logic [63:0] amag_r;
  logic        aneg_r;
  logic [63:0] udiff_r;
  logic [63:0] utud_r;
  logic [63:0] gp_r;
  logic [63:0] dloss_r;
  logic [63:0] dreg_r;
  logic [63:0] gw_r;
  logic [63:0] l1_r;
  logic [63:0] loss_r;
  logic [63:0] sqsum_r;
  logic [63:0] logsum_r;
  logic        err_r;
  logic        perr_r;
  logic [DATA_W-1:0] un_r;
  logic [5:0]  e_r;
  logic [KW-1:0] k_r;
  logic [63:0] tval_r;
  logic [63:0] lnm_r;

  logic        mul_start_r;
  logic [63:0] mul_a_r;
  logic [63:0] mul_b_r;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        div_start_r;
  logic [63:0] div_n_r;
  logic [63:0] div_d_r;
  logic        div_done;
  logic [63:0] div_q;

  logic        ov_r;
  res_t        res_r;

  logic [CW-1:0] bc_w;
  logic [BW-1:0] bsel;
  logic [63:0]   b64;
  logic [63:0]   diff64;
  logic [63:0]   u64;
  logic [51:0]   kprod;
  logic signed [7:0]  em;
  logic signed [63:0] xsum;
  logic [63:0]   lnv;
  logic [63:0]   dl;
  logic [63:0]   dr;

  always_comb begin
    bc_w = CW'(cfg.batch_count);
    if (bc_w == '0) begin
      bsel = BW'(1);
    end else if (bc_w > CW'(MAX_BATCH)) begin
      bsel = BW'(MAX_BATCH);
    end else begin
      bsel = BW'(bc_w);
    end
    b64    = 64'(bsel);
    diff64 = {{(64-DATA_W-1){it_r.diff[DATA_W]}}, it_r.diff};
    u64    = 64'(it_r.u);
    kprod  = 52'(un_r[DATA_W-2:0]) * 52'(LOG_TABLE_SIZE);
    em     = $signed({2'b00, e_r}) - $signed(8'(FRAC_BITS));
    xsum   = $signed(lnm_r) + $signed(tval_r) + $signed(RND);
    lnv    = 64'(xsum >>> (30 - FRAC_BITS));
    dl     = it_r.wneg ? sat_neg(dloss_r) : dloss_r;
    dr     = it_r.wneg ? sat_neg(dreg_r) : dreg_r;
  end

  assign q_ready   = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_res   = res_r;

  mwdl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  mwdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_n_r),
    .den   (div_d_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      ov_r        <= 1'b0;
      sqsum_r     <= '0;
      logsum_r    <= '0;
      err_r       <= 1'b0;
    end else begin
      // start strobes last one cycle; no state raises them twice in a row
      if (mul_start_r) mul_start_r <= 1'b0;
      if (div_start_r) div_start_r <= 1'b0;
      if (ov_r && out_ready && (st_r != ST_OUT)) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            it_r        <= q_item;
            gw_r        <= '0;
            loss_r      <= '0;
            perr_r      <= 1'b0;
            div_n_r     <= cfg.grad_scale[DATA_W-1] ?
                           (64'd0 - 64'($signed(cfg.grad_scale))) : 64'(cfg.grad_scale);
            div_d_r     <= b64;
            div_start_r <= 1'b1;
            st_r        <= ST_ALPHA;
          end
        end
        ST_ALPHA: begin
          if (div_done) begin
            amag_r      <= div_q;
            aneg_r      <= cfg.grad_scale[DATA_W-1] && (div_q != '0);
            alpha_r     <= cfg.grad_scale[DATA_W-1] ? (64'd0 - div_q) : div_q;
            mul_a_r     <= u64;
            mul_b_r     <= diff64;
            mul_start_r <= 1'b1;
            st_r        <= ST_M1;
          end
        end
        ST_M1: begin
          if (mul_done) begin
            udiff_r     <= mul_res;
            mul_a_r     <= u64;
            mul_b_r     <= mul_res;
            mul_start_r <= 1'b1;
            st_r        <= ST_M2;
          end
        end
        ST_M2: begin
          if (mul_done) begin
            utud_r      <= mul_res;
            mul_a_r     <= diff64;
            mul_b_r     <= mul_res;
            mul_start_r <= 1'b1;
            st_r        <= ST_M3;
          end
        end
        ST_M3: begin
          if (mul_done) begin
            sqsum_r     <= sat_add(sqsum_r, mul_res);
            mul_a_r     <= alpha_r;
            mul_b_r     <= utud_r;
            mul_start_r <= 1'b1;
            st_r        <= ST_M4;
          end
        end
        ST_M4: begin
          if (mul_done) begin
            gp_r <= mul_res;
            if (it_r.gterm) begin
              mul_a_r     <= udiff_r;
              mul_b_r     <= diff64;
              mul_start_r <= 1'b1;
              st_r        <= ST_M5;
            end else begin
              st_r <= ST_FIN;
            end
          end
        end
        ST_M5: begin
          if (mul_done) begin
            mul_a_r     <= alpha_r;
            mul_b_r     <= mul_res;
            mul_start_r <= 1'b1;
            st_r        <= ST_M6;
          end
        end
        ST_M6: begin
          if (mul_done) begin
            dloss_r <= mul_res;
            if (it_r.u == '0) begin
              // zero weight: regularizer term pinned at the rail opposite alpha
              perr_r <= 1'b1;
              if (amag_r == '0) begin
                dreg_r <= '0;
              end else begin
                dreg_r <= aneg_r ? SMAX : SMIN;
              end
              st_r <= ST_COMB;
            end else begin
              div_n_r     <= amag_r << FRAC_BITS;
              div_d_r     <= u64;
              div_start_r <= 1'b1;
              st_r        <= ST_DIVQ;
            end
          end
        end
        ST_DIVQ: begin
          if (div_done) begin
            dreg_r <= aneg_r ? div_q : (64'd0 - div_q);
            un_r   <= it_r.u;
            e_r    <= 6'(DATA_W - 1);
            st_r   <= ST_LNORM;
          end
        end
        ST_LNORM: begin
          if (un_r[DATA_W-1]) begin
            st_r <= ST_LK;
          end else begin
            un_r <= {un_r[DATA_W-2:0], 1'b0};
            e_r  <= e_r - 1'b1;
          end
        end
        ST_LK: begin
          k_r  <= KW'(kprod >> (DATA_W - 1));
          st_r <= ST_LT;
        end
        ST_LT: begin
          tval_r <= LOG_TAB[k_r];
          lnm_r  <= 64'($signed({{56{em[7]}}, em}) * $signed(LN2_Q30));
          st_r   <= ST_LSUM;
        end
        ST_LSUM: begin
          logsum_r <= sat_add(logsum_r, lnv);
          st_r     <= ST_COMB;
        end
        ST_COMB: begin
          gw_r  <= sat_add(dl, dr);
          err_r <= err_r | perr_r;
          st_r  <= ST_FIN;
        end
        ST_FIN: begin
          if (!it_r.last) begin
            st_r <= ST_OUT;
          end else if (err_r) begin
            loss_r <= SMAX;
            st_r   <= ST_OUT;
          end else begin
            div_n_r     <= sqsum_r;
            div_d_r     <= b64 << 1;
            div_start_r <= 1'b1;
            st_r        <= ST_LD1;
          end
        end
        ST_LD1: begin
          if (div_done) begin
            l1_r        <= div_q;
            div_n_r     <= logsum_r[63] ? (64'd0 - logsum_r) : logsum_r;
            div_d_r     <= b64;
            div_start_r <= 1'b1;
            st_r        <= ST_LD2;
          end
        end
        ST_LD2: begin
          if (div_done) begin
            loss_r <= sat_sub(l1_r, logsum_r[63] ? (64'd0 - div_q) : div_q);
            st_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ov_r || out_ready) begin
            ov_r             <= 1'b1;
            res_r.gp         <= gp_r;
            res_r.gt         <= sat_neg(gp_r);
            res_r.gw         <= gw_r;
            res_r.loss       <= loss_r;
            res_r.math_error <= it_r.last ? err_r : perr_r;
            res_r.eob        <= it_r.last;
            if (it_r.last) begin
              sqsum_r  <= '0;
              logsum_r <= '0;
              err_r    <= 1'b0;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/masked_weighted_depth_loss_core.sv
// Masked, weighted depth loss. Pixels (predicted, target, weight, all signed
// Q24.16) stream in; each gives one result with its prediction, label and
// weight gradients, and the last pixel of a batch also carries the batch
// loss and raises tlast. A front stage classifies each pixel (mask test,
// difference, weight magnitude) into a four-entry queue; the back end works
// one pixel at a time with a shared 64-bit multiplier (four 32x32 passes)
// and a one-bit-a-cycle divider. An unmasked pixel in weighted mode with a
// nonzero weight also uses the divider and a leading-one search for the log
// term; the last pixel of a batch adds the two loss divisions unless the
// batch saw an error. The user must see that configuration is written only
// while the block is idle; the block itself does not enforce it.
module masked_weighted_depth_loss_core #(
  parameter int FRAC_BITS      = 16,
  parameter int LOG_TABLE_SIZE = 256,
  parameter int MAX_BATCH      = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // predicted, target, weight
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata,  // grad_predicted, grad_target, grad_weight, loss_value
  output logic         out_tuser,  // math_error
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import mwdl_pkg::*;

  cfg_t  cfg_r;
  logic  wr_en;
  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;
  logic  bq_valid;
  logic  bq_ready;
  item_t bq_item;
  res_t  res;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.batch_count   <= 11'd1;
      cfg_r.weighted_mode <= 1'b1;
      cfg_r.grad_scale    <= 40'd65536;
      cfg_r.mask_code     <= 40'(-64'sd6553600000);
    end else if (wr_en) begin
      case (cfg_paddr[4:3])
        REG_BATCH_COUNT:   cfg_r.batch_count   <= cfg_pwdata[10:0];
        REG_WEIGHTED_MODE: cfg_r.weighted_mode <= cfg_pwdata[0];
        REG_GRAD_SCALE:    cfg_r.grad_scale    <= cfg_pwdata[DATA_W-1:0];
        REG_MASK_CODE:     cfg_r.mask_code     <= cfg_pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_BATCH_COUNT:   cfg_prdata = 64'(cfg_r.batch_count);
      REG_WEIGHTED_MODE: cfg_prdata = 64'(cfg_r.weighted_mode);
      REG_GRAD_SCALE:    cfg_prdata = 64'($signed(cfg_r.grad_scale));
      REG_MASK_CODE:     cfg_prdata = 64'($signed(cfg_r.mask_code));
      default:           cfg_prdata = '0;
    endcase
  end

  mwdl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .pred     (in_tdata[39:0]),
    .targ     (in_tdata[79:40]),
    .wt       (in_tdata[119:80]),
    .last     (in_tlast),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  mwdl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_item  (bq_item)
  );

  mwdl_back #(
    .FRAC_BITS      (FRAC_BITS),
    .LOG_TABLE_SIZE (LOG_TABLE_SIZE),
    .MAX_BATCH      (MAX_BATCH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.loss, res.gw, res.gt, res.gp};
  assign out_tuser = res.math_error;
  assign out_tlast = res.eob;

  // label gradient is the saturated negation of the prediction gradient
  a_gt_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[127:64] ==
      ((out_tdata[63:0] == 64'h8000_0000_0000_0000) ? 64'h7fff_ffff_ffff_ffff :
       (64'd0 - out_tdata[63:0]))))
    else $error("grad_target mismatch");

  // loss only on the last pixel of a batch
  a_loss_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[255:192] == 64'd0))
    else $error("loss on non-final pixel");

endmodule

### sim/mwdl_checker.sv
`timescale 1ns / 1ps
module mwdl_checker
  import mwdl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [255:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);

  localparam int FRAC    = 16;
  localparam int TAB_N   = 256;
  localparam int BATCH_MAX = 1024;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    longint gp, gt, gw, loss;
    bit     math_error, eob;
  } pixel_grad_t;

  pixel_grad_t grad_q[$];

  longint ln_tab[TAB_N];
  longint ln2_q30;

  logic [10:0]        m_batch = 11'd1;
  logic               m_weighted = 1'b1;
  logic signed [39:0] m_scale = 40'sd65536;
  logic signed [39:0] m_mask = -40'sd6553600000;
  longint             sq_sum, lg_sum;
  bit                 err_seen;

  function automatic longint unsigned magnitude(longint a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  function automatic longint clamp_mag(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (m > lim) m = lim;
    return neg ? longint'(64'd0 - m) : longint'(m);
  endfunction

  function automatic longint clamp65(logic signed [64:0] s);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < 65'(S64_MIN)) return S64_MIN;
    return longint'(s[63:0]);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp65(65'(a) + 65'(b));
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clamp65(65'(a) - 65'(b));
  endfunction

  function automatic longint neg_sat(longint a);
    return a == S64_MIN ? S64_MAX : -a;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0]    p;
    longint unsigned lo;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    lo = p[FRAC +: 64];
    if (p[127:FRAC+64] != 0) lo = '1;
    return clamp_mag(lo, (a < 0) != (b < 0));
  endfunction

  // atanh series: 2*atanh(num/den) = ln((den+num)/(den-num)), Q30
  function automatic longint atanh_q30(longint unsigned num, longint unsigned den);
    longint unsigned z, z2, term, acc, n;
    z = (num << 30) / den;
    z2 = (z * z) >> 30;
    term = z;
    acc = 0;
    for (n = 1; term != 0 && n < 200; n += 2) begin
      acc += term / n;
      term = (term * z2) >> 30;
    end
    return longint'(2 * acc);
  endfunction

  function automatic longint ln_q(longint unsigned u);
    int              e;
    longint unsigned k;
    longint          x;
    e = 0;
    while (e < 63 && (u >> (e + 1)) != 0) e++;
    k = ((u - (64'd1 << e)) * TAB_N) >> e;
    if (k >= TAB_N) k = TAB_N - 1;
    x = longint'(e - FRAC) * ln2_q30 + ln_tab[k];
    x += 64'sd1 << (29 - FRAC);
    return x >>> (30 - FRAC);
  endfunction

  function automatic pixel_grad_t depth_loss_grads(logic signed [39:0] pred,
                                                   logic signed [39:0] targ,
                                                   logic signed [39:0] wt, bit last);
    pixel_grad_t r;
    longint b, alpha, diff, u, udiff, utudiff, gp, gw, dloss, dreg;
    bit masked, perr;
    longint unsigned q;
    masked = (targ == m_mask);
    perr = 0;
    gw = 0;
    b = m_batch;
    if (b < 1) b = 1;
    if (b > BATCH_MAX) b = BATCH_MAX;
    alpha = longint'(m_scale) / b;
    diff = masked ? 0 : longint'(pred) - longint'(targ);
    u = (masked || !m_weighted) ? (64'sd1 << FRAC) : longint'(magnitude(longint'(wt)));
    udiff = qmul(u, diff);
    utudiff = qmul(u, udiff);
    sq_sum = add_sat(sq_sum, qmul(diff, utudiff));
    gp = qmul(alpha, utudiff);
    if (m_weighted && !masked) begin
      dloss = qmul(alpha, qmul(udiff, diff));
      if (u == 0) begin
        // zero weight: regularizer gradient pinned opposite alpha
        perr = 1;
        dreg = alpha > 0 ? S64_MIN : (alpha < 0 ? S64_MAX : 0);
      end else begin
        q = (magnitude(alpha) << FRAC) / longint'(u);
        dreg = clamp_mag(q, !(alpha < 0));
        lg_sum = add_sat(lg_sum, ln_q(u));
      end
      if (wt < 0) begin
        dloss = neg_sat(dloss);
        dreg = neg_sat(dreg);
      end
      gw = add_sat(dloss, dreg);
    end
    if (perr) err_seen = 1;
    r.gp = gp;
    r.gt = neg_sat(gp);
    r.gw = gw;
    r.loss = 0;
    r.eob = last;
    r.math_error = last ? err_seen : perr;
    if (last) begin
      r.loss = err_seen ? S64_MAX : sub_sat(sq_sum / (2 * b), lg_sum / b);
      sq_sum = 0;
      lg_sum = 0;
      err_seen = 0;
    end
    return r;
  endfunction

  initial begin
    for (int k = 0; k < TAB_N; k++) ln_tab[k] = atanh_q30(k, 2 * TAB_N + k);
    ln2_q30 = atanh_q30(1, 3);
    fail_count = 0;
    sq_sum = 0;
    lg_sum = 0;
    err_seen = 0;
  end

  assign pending = grad_q.size();

  task automatic report(string what, longint exp_v, longint act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    pixel_grad_t e;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_BATCH_COUNT:   m_batch = cfg_pwdata[10:0];
          REG_WEIGHTED_MODE: m_weighted = cfg_pwdata[0];
          REG_GRAD_SCALE:    m_scale = cfg_pwdata[39:0];
          REG_MASK_CODE:     m_mask = cfg_pwdata[39:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        grad_q.push_back(depth_loss_grads(in_tdata[39:0], in_tdata[79:40],
                                          in_tdata[119:80], in_tlast));
      if (out_tvalid && out_tready) begin
        if (grad_q.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          e = grad_q.pop_front();
          if (out_tdata[63:0] != e.gp)     report("grad_predicted", e.gp, out_tdata[63:0]);
          if (out_tdata[127:64] != e.gt)   report("grad_target", e.gt, out_tdata[127:64]);
          if (out_tdata[191:128] != e.gw)  report("grad_weight", e.gw, out_tdata[191:128]);
          if (out_tdata[255:192] != e.loss) report("loss_value", e.loss, out_tdata[255:192]);
          if (out_tuser != e.math_error)   report("math_error", e.math_error, out_tuser);
          if (out_tlast != e.eob)          report("end_of_batch", e.eob, out_tlast);
        end
      end
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mwdl_pkg::*;

  localparam logic [39:0] Q_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] Q_MIN = 40'h80_0000_0000;
  localparam logic [39:0] Q_ONE = 40'd65536;
  localparam logic [39:0] MASK_DEFAULT = -40'sd6553600000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  int          fail_count, pending;
  bit          quiet = 0;
  int          out_hold = 0;
  logic [39:0] cur_mask = MASK_DEFAULT;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  masked_weighted_depth_loss_core dut (.*);

  mwdl_checker chk (.*);

  // result-side backpressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [39:0] pred, logic [39:0] targ, logic [39:0] wt, bit last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tdata <= {wt, targ, pred};
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [39:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 40'({$urandom, $urandom});
      1: case ($urandom_range(0, 5))
           0: return Q_MAX;
           1: return Q_MIN;
           2: return '0;
           3: return Q_ONE;
           4: return -Q_ONE;
           default: return 40'd1;
         endcase
      2: return 40'($urandom_range(0, 32'h00FF_FFFF));
      3: return -40'($urandom_range(0, 32'h00FF_FFFF));
      default: return 40'($signed({$urandom_range(0, 1) ? 1'b1 : 1'b0,
                                   20'($urandom)}));
    endcase
  endfunction

  task automatic random_batches(int n);
    int done, len;
    logic [39:0] t, w;
    done = 0;
    while (done < n) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        t = ($urandom_range(0, 5) == 0) ? cur_mask : pick_value();
        w = ($urandom_range(0, 19) == 0) ? 40'd0 : pick_value();
        send_pixel(pick_value(), t, w, i == len - 1);
        done++;
      end
    end
  endtask

  task automatic set_config(logic [10:0] bc, bit wm, logic [39:0] gs, logic [39:0] mc);
    reg_write(REG_BATCH_COUNT, 64'(bc));
    reg_write(REG_WEIGHTED_MODE, 64'(wm));
    reg_write(REG_GRAD_SCALE, {{24{gs[39]}}, gs});
    reg_write(REG_MASK_CODE, {{24{mc[39]}}, mc});
    cur_mask = mc;
  endtask

  initial begin
    #(64'd40_000_000);
    $display("** masked_weighted_depth_loss_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pixels under reset configuration
    send_pixel(Q_MAX, Q_MIN, Q_MAX, 0);
    send_pixel(Q_MIN, Q_MAX, Q_MIN, 0);
    send_pixel(Q_ONE, '0, Q_ONE, 0);
    send_pixel(Q_ONE, '0, -Q_ONE, 0);
    send_pixel(40'd12345, MASK_DEFAULT, Q_MAX, 0);
    send_pixel('0, '0, 40'd1, 0);
    send_pixel(-Q_ONE, Q_ONE, 40'd3 << 16, 1);
    send_pixel(Q_ONE, '0, 40'd0, 0);        // zero weight poisons the batch loss
    send_pixel(Q_MAX, Q_MAX, -40'd7, 1);
    send_pixel(Q_MIN, Q_MAX, 40'd1, 1);
    send_pixel('0, MASK_DEFAULT, '0, 1);
    drain();
    random_batches(150);
    drain();

    set_config(11'd3, 1'b1, Q_ONE, MASK_DEFAULT);
    random_batches(180);
    drain();
    set_config(11'd0, 1'b0, -(40'd3 << 16), Q_MAX);
    send_pixel(40'd5, '0, '0, 1);
    random_batches(180);
    drain();
    set_config(11'd1024, 1'b1, Q_MIN, '0);
    random_batches(180);
    drain();
    set_config(11'd2047, 1'b1, Q_MAX, Q_MIN);
    send_pixel(Q_MAX, Q_MIN, Q_MAX, 1);
    random_batches(180);
    drain();
    set_config(11'd7, 1'b1, '0, 40'($urandom));
    random_batches(180);
    drain();
    set_config(11'd1, 1'b0, 40'({$urandom, $urandom}), MASK_DEFAULT);
    quiet = 1;
    random_batches(180);
    drain();

    if (fail_count == 0)
      $display("** masked_weighted_depth_loss_core: PASSED **");
    else
      $display("** masked_weighted_depth_loss_core: FAILED **");
    $finish;
  end

endmodule
